// ===== rtl/mpbfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mpbfa_pkg;
    localparam int NUM_POOLS   = 4;
    localparam int REGION_REGS = 4;
    localparam int MAX_ENTRIES = 64;
    localparam int POOL_W      = $clog2(REGION_REGS);
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TBL_DEPTH   = REGION_REGS * MAX_ENTRIES;
    localparam int ENTRY_W     = 64;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [2:0] REG_KINDS = 3'd4;
    localparam logic [2:0] REG_COUNT = 3'd5;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_entry;

    // table capacity: max(16, size/1024), capped at MAX_ENTRIES
    function automatic logic [CNT_W-1:0] pool_cap(input logic [31:0] sz);
        logic [21:0] c;
        logic [CNT_W-1:0] r;
        begin
            c = sz[31:10];
            if (c < 22'd16) begin
                r = CNT_W'(16);
            end else if (c > 22'(MAX_ENTRIES)) begin
                r = CNT_W'(MAX_ENTRIES);
            end else begin
                r = CNT_W'(c);
            end
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/mpbfa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpbfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/mpbfa_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mpbfa_alu (
    input  wire logic [33:0] i_a,
    input  wire logic [33:0] i_b,
    output logic      [33:0] o_diff,
    output logic             o_borrow
);
    logic [34:0] w_sub;

    assign w_sub    = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_sub[33:0];
    assign o_borrow = w_sub[34];
endmodule
`default_nettype wire

// ===== rtl/multi_pool_best_fit_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Response: a rejected request (zero/oversized size, null free, unused action) answers the
// cycle after acceptance; otherwise the answer follows a walk over the pools, a scan of the
// table entries and a shift of the entries on insert/remove. Throughput: one transaction at
// a time; the sequencer steps the table entries one by one through the shared subtractor.
// Reset (synchronous, active low) clears the configuration registers, block counts and
// handshake state; the table RAM is not cleared, entries are only read once written.
module multi_pool_best_fit_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // action[1:0], req_bytes[33:2], kind_mask[49:34], release_address[81:50]
    input  wire logic [87:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // block_address[31:0], success[32], free_total[66:33]
    output logic      [71:0] o_m_axis_tdata,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [5:0]  i_paddr,
    input  wire logic [63:0] i_pwdata,
    output logic      [63:0] o_prdata,
    output logic             o_pready
);
    import mpbfa_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_POOL = 4'd1;
    localparam logic [3:0] ST_A_RD = 4'd2;
    localparam logic [3:0] ST_A_EV = 4'd3;
    localparam logic [3:0] ST_S_RD = 4'd4;
    localparam logic [3:0] ST_S_WR = 4'd5;
    localparam logic [3:0] ST_INS  = 4'd6;
    localparam logic [3:0] ST_F_RD = 4'd7;
    localparam logic [3:0] ST_F_EV = 4'd8;
    localparam logic [3:0] ST_M_RD = 4'd9;
    localparam logic [3:0] ST_M_WR = 4'd10;
    localparam logic [3:0] ST_Q_RD = 4'd11;
    localparam logic [3:0] ST_Q_EV = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    logic [63:0]       r_region [REGION_REGS];
    logic [63:0]       r_kinds;
    logic [2:0]        r_count;
    logic [CNT_W-1:0]  r_used [REGION_REGS];

    logic [3:0]        r_state;
    logic [1:0]        r_act;
    logic [31:0]       r_need;
    logic [15:0]       r_mask;
    logic [31:0]       r_rel;
    logic [POOL_W:0]   r_pool;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_j;
    logic [31:0]       r_prev;
    logic [31:0]       r_end;
    logic [31:0]       r_ptotal;
    logic              r_found;
    logic [CNT_W-1:0]  r_ins_pos;
    logic [31:0]       r_best_start;
    logic [31:0]       r_best_gap;
    logic [33:0]       r_total;
    logic [31:0]       r_addr_o;
    logic              r_ok;

    // input unpack
    logic [1:0]  w_action;
    logic [31:0] w_nbytes;
    logic [15:0] w_kmask;
    logic [31:0] w_rel;
    assign w_action = i_s_axis_tdata[1:0];
    assign w_nbytes = i_s_axis_tdata[33:2];
    assign w_kmask  = i_s_axis_tdata[49:34];
    assign w_rel    = i_s_axis_tdata[81:50];

    // current pool geometry
    logic [POOL_W-1:0] w_pidx;
    logic [63:0]       w_reg;
    logic [31:0]       w_sz;
    logic [CNT_W-1:0]  w_cap;
    logic [31:0]       w_reserve;
    logic              w_en;
    logic              w_kind;
    logic [CNT_W-1:0]  w_used;
    logic [2:0]        w_active;

    assign w_pidx    = r_pool[POOL_W-1:0];
    assign w_reg     = r_region[w_pidx];
    assign w_sz      = w_reg[31:0];
    assign w_cap     = pool_cap(w_sz);
    assign w_reserve = 32'({w_cap, 3'b000});
    assign w_en      = (w_sz >= 32'd256);
    assign w_kind    = ((r_kinds[{w_pidx, 4'b0000} +: 16] & r_mask) != 16'd0);
    assign w_used    = r_used[w_pidx];
    assign w_active  = (r_count > 3'(NUM_POOLS)) ? 3'(NUM_POOLS) : r_count;

    // table RAM
    logic                          w_we;
    logic [POOL_W+IDX_W-1:0]       w_waddr;
    logic [POOL_W+IDX_W-1:0]       w_raddr;
    t_entry                        w_wdata;
    logic [ENTRY_W-1:0]            w_rdata;
    t_entry                        w_q;

    assign w_q = t_entry'(w_rdata);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {w_pidx, r_j[IDX_W-1:0]};
        w_wdata = w_q;
        w_raddr = {w_pidx, r_idx[IDX_W-1:0]};
        case (r_state)
            ST_S_RD: w_raddr = {w_pidx, IDX_W'(r_j - 1'b1)};
            ST_S_WR: w_we = 1'b1;
            ST_M_RD: w_raddr = {w_pidx, IDX_W'(r_j + 1'b1)};
            ST_M_WR: w_we = 1'b1;
            ST_INS: begin
                w_we    = 1'b1;
                w_waddr = {w_pidx, r_ins_pos[IDX_W-1:0]};
                w_wdata = '{start: r_best_start, len: r_need};
            end
            default: ;
        endcase
    end

    mpbfa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TBL_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // shared subtractor: gap during alloc scan, free-byte count during query
    logic [33:0] w_alu_a;
    logic [33:0] w_alu_b;
    logic [33:0] w_diff;
    logic        w_borrow;
    logic        w_in_tbl;
    logic [31:0] w_next;

    assign w_in_tbl = (r_idx < w_used);
    assign w_next   = w_in_tbl ? w_q.start : r_end;

    always_comb begin
        if (r_state == ST_Q_EV) begin
            w_alu_a = {2'b00, r_ptotal};
            w_alu_b = {2'b00, w_q.len};
        end else begin
            w_alu_a = {2'b00, w_next};
            w_alu_b = {2'b00, r_prev};
        end
    end

    mpbfa_alu u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .o_diff  (w_diff),
        .o_borrow(w_borrow)
    );

    logic [31:0]      w_gap;
    logic             w_take;
    logic             w_fin_found;
    assign w_gap       = w_diff[31:0];
    assign w_take      = (r_need <= w_gap) && (!r_found || (w_gap < r_best_gap));
    assign w_fin_found = r_found || w_take;

    logic w_cfg_wr;
    logic [2:0] w_cfg_idx;
    assign w_cfg_wr  = i_psel && i_penable && i_pwrite && o_pready;
    assign w_cfg_idx = i_paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kinds <= '0;
            r_count <= '0;
            for (int k = 0; k < REGION_REGS; k++) begin
                r_region[k] <= '0;
                r_used[k]   <= '0;
            end
        end else begin
            if (w_cfg_wr) begin
                if (w_cfg_idx < 3'(REGION_REGS)) begin
                    r_region[w_cfg_idx[POOL_W-1:0]] <= i_pwdata;
                    r_used[w_cfg_idx[POOL_W-1:0]]   <= '0;
                end else if (w_cfg_idx == REG_KINDS) begin
                    r_kinds <= i_pwdata;
                end else if (w_cfg_idx == REG_COUNT) begin
                    r_count <= i_pwdata[2:0];
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_act    <= w_action;
                        r_need   <= (w_nbytes + 32'd3) & ~32'd3;
                        r_mask   <= w_kmask;
                        r_rel    <= w_rel;
                        r_pool   <= '0;
                        r_ok     <= (w_action == ACT_QUERY);
                        r_addr_o <= '0;
                        r_total  <= '0;
                        if ((w_action == ACT_ALLOC && w_nbytes != 32'd0
                                && w_nbytes <= 32'hFFFF_FFFC)
                                || (w_action == ACT_FREE && w_rel != 32'd0)
                                || w_action == ACT_QUERY) begin
                            r_state <= ST_POOL;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_POOL: begin
                    r_prev   <= w_reg[63:32] + w_reserve;
                    r_end    <= w_reg[63:32] + w_sz;
                    r_ptotal <= w_sz - w_reserve;
                    r_idx    <= '0;
                    r_found  <= 1'b0;
                    if (r_pool >= w_active) begin
                        r_state <= ST_DONE;
                    end else begin
                        case (r_act)
                            ACT_ALLOC: begin
                                if (w_kind && w_en && w_used < w_cap) begin
                                    r_state <= ST_A_RD;
                                end else begin
                                    r_pool <= r_pool + 1'b1;
                                end
                            end
                            ACT_FREE: begin
                                if (w_used != '0) begin
                                    r_state <= ST_F_RD;
                                end else begin
                                    r_pool <= r_pool + 1'b1;
                                end
                            end
                            default: begin
                                if (w_kind && w_en) begin
                                    r_state <= ST_Q_RD;
                                end else begin
                                    r_pool <= r_pool + 1'b1;
                                end
                            end
                        endcase
                    end
                end
                ST_A_RD: r_state <= ST_A_EV;
                ST_A_EV: begin
                    if (w_take) begin
                        r_found      <= 1'b1;
                        r_ins_pos    <= r_idx;
                        r_best_start <= r_prev;
                        r_best_gap   <= w_gap;
                    end
                    if (w_in_tbl) begin
                        r_prev  <= w_q.start + w_q.len;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_A_RD;
                    end else if (w_fin_found) begin
                        r_j     <= w_used;
                        r_state <= ST_S_RD;
                    end else begin
                        r_pool  <= r_pool + 1'b1;
                        r_state <= ST_POOL;
                    end
                end
                ST_S_RD: begin
                    r_state <= (r_j > r_ins_pos) ? ST_S_WR : ST_INS;
                end
                ST_S_WR: begin
                    r_j     <= r_j - 1'b1;
                    r_state <= ST_S_RD;
                end
                ST_INS: begin
                    r_used[w_pidx] <= w_used + 1'b1;
                    r_addr_o       <= r_best_start;
                    r_ok           <= 1'b1;
                    r_state        <= ST_DONE;
                end
                ST_F_RD: r_state <= ST_F_EV;
                ST_F_EV: begin
                    if (w_q.start == r_rel) begin
                        r_j     <= r_idx;
                        r_state <= ST_M_RD;
                    end else if (CNT_W'(r_idx + 1'b1) == w_used) begin
                        r_pool  <= r_pool + 1'b1;
                        r_state <= ST_POOL;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_F_RD;
                    end
                end
                ST_M_RD: begin
                    if (CNT_W'(r_j + 1'b1) < w_used) begin
                        r_state <= ST_M_WR;
                    end else begin
                        r_used[w_pidx] <= w_used - 1'b1;
                        r_ok           <= 1'b1;
                        r_state        <= ST_DONE;
                    end
                end
                ST_M_WR: begin
                    r_j     <= r_j + 1'b1;
                    r_state <= ST_M_RD;
                end
                ST_Q_RD: begin
                    if (r_idx == w_used) begin
                        r_total <= r_total + {2'b00, r_ptotal};
                        r_pool  <= r_pool + 1'b1;
                        r_state <= ST_POOL;
                    end else begin
                        r_state <= ST_Q_EV;
                    end
                end
                ST_Q_EV: begin
                    // saturate at zero
                    r_ptotal <= w_borrow ? 32'd0 : w_diff[31:0];
                    r_idx    <= r_idx + 1'b1;
                    r_state  <= ST_Q_RD;
                end
                ST_DONE: begin
                    if (i_m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_DONE);
    assign o_m_axis_tdata  = {5'b00000, r_total, r_ok, r_addr_o};
    assign o_pready        = 1'b1;

    always_comb begin
        case (w_cfg_idx)
            3'd0, 3'd1, 3'd2, 3'd3: o_prdata = r_region[w_cfg_idx[POOL_W-1:0]];
            REG_KINDS: o_prdata = r_kinds;
            REG_COUNT: o_prdata = {61'd0, r_count};
            default: o_prdata = '0;
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("ready and result valid together");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("accepted a second request while busy");

    a_addr_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[31:0] != 32'd0) |-> o_m_axis_tdata[32])
        else $error("address returned without success");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used[0] <= CNT_W'(MAX_ENTRIES))
        else $error("block count exceeds table size");
endmodule
`default_nettype wire
